/* sv/assert_macros.svh */
// Assertion macros for the polygon/plane intersection block.
// Needs clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define PPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen
`define PPI_NEVER(label, expr, msg) \
	`PPI_ASSERT(label, !(expr), msg)
`endif

/* sv/ppi_pkg.sv */
// Shared types and constants of the polygon/plane intersection block.
// No dependencies; used by ppi_ctrl, ppi_datapath and the top level.
`timescale 1ns / 1ps
package ppi_pkg;

	localparam int CFG_W     = 63;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_TOL = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSEST   = 3'd7;

	localparam logic [1:0] SIDE_ON    = 2'd0;
	localparam logic [1:0] SIDE_ABOVE = 2'd1;
	localparam logic [1:0] SIDE_BELOW = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	// on-plane and parallel-edge tolerance on dot products
	localparam logic [67:0] SIDE_TOL = 68'd0;
	// quotient bits produced by the divider; larger quotients are capped
	localparam int          DIV_STEPS = 35;
	localparam logic [35:0] CAP_MAG   = 36'h4_0000_0000;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         status;
		logic               last_of_polygon;
	} result_t;

	typedef enum logic [2:0] {
		MAC_DOT_VP = 3'd0,
		MAC_DOT_BA = 3'd1,
		MAC_DOT_PA = 3'd2,
		MAC_CHUNK  = 3'd3,
		MAC_SQ_RP  = 3'd4,
		MAC_SQ_QP  = 3'd5
	} mac_mode_t;

	typedef enum logic [1:0] {
		EMIT_PENDING = 2'd0,
		EMIT_BEST    = 2'd1,
		EMIT_NONE    = 2'd2,
		EMIT_SHORT   = 2'd3
	} emit_kind_t;

	typedef struct packed {
		logic       ld_v;
		logic       mac_go;
		mac_mode_t  mac_mode;
		logic       ld_side;
		logic       dec_first;
		logic       ld_den;
		logic       ld_num;
		logic       r_from_a;
		logic       comp_clr;
		logic       comp_inc;
		logic       div_init;
		logic       div_go;
		logic       fin;
		logic       set_pending;
		logic       best_upd;
		logic       advance;
		logic       clear_poly;
		logic       emit;
		emit_kind_t emit_kind;
		logic       emit_last;
		logic       edge_close;
	} dp_cmd_t;

	typedef struct packed {
		logic mac_done;
		logic div_done;
		logic side_change;
		logic close_needed;
		logic den_small;
		logic far;
		logic pend_valid;
		logic closest;
		logic out_free;
		logic comp_last;
		logic last_v;
		logic seen_zero;
	} dp_stat_t;

	function automatic logic [31:0] pick(vec3_t v, logic [1:0] i);
		logic [31:0] r;
		case (i)
			2'd0: r = v[0];
			2'd1: r = v[1];
			2'd2: r = v[2];
			default: r = v[0];
		endcase
		return r;
	endfunction

endpackage

/* sv/ppi_datapath.sv */
// Datapath: configuration registers, polygon state, shared multiply-accumulate,
// restoring divider and result register. Depends on ppi_pkg.
`timescale 1ns / 1ps
module ppi_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ppi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppi_pkg::CFG_W-1:0]      cfg_data,
	input  ppi_pkg::vertex_t               in_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output ppi_pkg::result_t               out_data,
	input  ppi_pkg::dp_cmd_t               cmd,
	output ppi_pkg::dp_stat_t              stat
);
	import ppi_pkg::*;

	vec3_t       normal_q, plane_q;
	logic [62:0] tol_q;
	logic        closest_q;

	vec3_t       v_q, first_q, prev_q, r_q, pend_q, best_q;
	logic        last_q;
	logic [1:0]  s_q, first_side_q, prev_side_q, seen_q;
	logic        pv_q, bv_q;
	logic [63:0] best_dist_q;

	logic [1:0]         mac_cnt_q;
	logic signed [67:0] prod_s1;
	logic [5:0]         shamt_s1;
	logic [100:0]       acc_q;

	logic signed [67:0] den_q, num_q;
	logic [1:0]         comp_q;

	logic [67:0] rem_q;
	logic [34:0] nlow_q, quo_q;
	logic        capf_q;
	logic [5:0]  div_cnt_q;

	result_t out_q;
	logic    out_valid_q;

	function automatic logic signed [32:0] sub33(logic [31:0] a, logic [31:0] b);
		return $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q  <= {32'd65536, 32'd0, 32'd0};
			plane_q   <= '0;
			tol_q     <= 63'd1;
			closest_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NORMAL_X:  normal_q[0] <= cfg_data[31:0];
				REG_NORMAL_Y:  normal_q[1] <= cfg_data[31:0];
				REG_NORMAL_Z:  normal_q[2] <= cfg_data[31:0];
				REG_PLANE_X:   plane_q[0]  <= cfg_data[31:0];
				REG_PLANE_Y:   plane_q[1]  <= cfg_data[31:0];
				REG_PLANE_Z:   plane_q[2]  <= cfg_data[31:0];
				REG_MERGE_TOL: tol_q       <= cfg_data;
				REG_CLOSEST:   closest_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// edge end points: a is the start, b the end
	vec3_t ea, eb;
	assign ea = cmd.edge_close ? v_q : prev_q;
	assign eb = cmd.edge_close ? first_q : v_q;

	// magnitudes of the stored dot products
	logic [67:0] dm, nm;
	logic [68:0] nm69;
	assign dm   = den_q[67] ? (~den_q + 68'd1) : den_q;
	assign nm   = num_q[67] ? (~num_q + 68'd1) : num_q;
	assign nm69 = {1'b0, nm};

	// edge difference of the component under work
	logic signed [32:0] cdiff;
	logic [32:0]        dmag;
	assign cdiff = sub33(pick(eb, comp_q), pick(ea, comp_q));
	assign dmag  = cdiff[32] ? (~cdiff + 33'd1) : cdiff;

	// multiply operand selection
	vec3_t              opa, opb;
	logic [31:0]        nsel;
	logic signed [32:0] d;
	logic signed [33:0] ma, mb;
	logic [22:0]        chunk;
	logic [5:0]         shamt;
	logic [67:0]        mul_full;

	always_comb begin
		case (cmd.mac_mode)
			MAC_DOT_VP: begin opa = v_q;     opb = plane_q; end
			MAC_DOT_BA: begin opa = eb;      opb = ea;      end
			MAC_DOT_PA: begin opa = plane_q; opb = ea;      end
			MAC_SQ_RP:  begin opa = r_q;     opb = pend_q;  end
			MAC_SQ_QP:  begin opa = pend_q;  opb = plane_q; end
			default:    begin opa = v_q;     opb = plane_q; end
		endcase
		nsel = pick(normal_q, mac_cnt_q);
		d    = sub33(pick(opa, mac_cnt_q), pick(opb, mac_cnt_q));
		case (mac_cnt_q)
			2'd1:    begin chunk = nm69[45:23]; shamt = 6'd23; end
			2'd2:    begin chunk = nm69[68:46]; shamt = 6'd46; end
			default: begin chunk = nm69[22:0];  shamt = 6'd0;  end
		endcase
		case (cmd.mac_mode)
			MAC_DOT_VP, MAC_DOT_BA, MAC_DOT_PA: begin
				ma = {{2{nsel[31]}}, nsel};
				mb = {d[32], d};
			end
			MAC_CHUNK: begin
				ma = {11'd0, chunk};
				mb = {1'b0, dmag};
			end
			default: begin
				ma = {d[32], d};
				mb = {d[32], d};
			end
		endcase
		if (cmd.mac_mode != MAC_CHUNK)
			shamt = 6'd0;
	end

	assign mul_full = {{34{ma[33]}}, ma} * {{34{mb[33]}}, mb};

	// three products, each registered in prod_s1 and accumulated in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_cnt_q <= 2'd0;
		end else if (cmd.mac_go) begin
			mac_cnt_q <= mac_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_go) begin
			prod_s1  <= mul_full;
			shamt_s1 <= shamt;
			if (mac_cnt_q == 2'd0)
				acc_q <= '0;
			else
				acc_q <= acc_q + ({{33{prod_s1[67]}}, prod_s1} << shamt_s1);
		end
	end

	// side of the vertex from the dot product in the accumulator
	logic [67:0] dot_mag;
	logic [1:0]  side_cur;
	assign dot_mag  = acc_q[67] ? (~acc_q[67:0] + 68'd1) : acc_q[67:0];
	assign side_cur = (dot_mag <= SIDE_TOL) ? SIDE_ON : (acc_q[67] ? SIDE_BELOW : SIDE_ABOVE);

	// divider step and final rounding
	logic [68:0] r2;
	logic        r2_ge;
	logic        rnd;
	logic [35:0] qr, qcap;
	logic        neg;
	logic [31:0] abase;
	logic signed [36:0] base37, sum37;
	logic [31:0] comp_res;

	assign r2    = {rem_q, nlow_q[34]};
	assign r2_ge = r2 >= {1'b0, dm};

	always_comb begin
		rnd    = {rem_q, 1'b0} >= {1'b0, dm};
		qr     = {1'b0, quo_q} + {35'd0, rnd};
		qcap   = (capf_q || qr > CAP_MAG) ? CAP_MAG : qr;
		neg    = num_q[67] ^ den_q[67] ^ cdiff[32];
		abase  = pick(ea, comp_q);
		base37 = {{5{abase[31]}}, abase};
		sum37  = neg ? base37 - $signed({1'b0, qcap}) : base37 + $signed({1'b0, qcap});
		// saturate to the signed 32-bit range
		if (!sum37[36] && (|sum37[35:31]))
			comp_res = 32'h7FFF_FFFF;
		else if (sum37[36] && !(&sum37[35:31]))
			comp_res = 32'h8000_0000;
		else
			comp_res = sum37[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= 6'd0;
		end else if (cmd.div_init) begin
			div_cnt_q <= 6'd0;
		end else if (cmd.div_go) begin
			div_cnt_q <= div_cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= {3'd0, acc_q[99:35]};
			capf_q <= {3'd0, acc_q[99:35]} >= dm;
			nlow_q <= acc_q[34:0];
			quo_q  <= '0;
		end else if (cmd.div_go) begin
			rem_q  <= r2_ge ? 68'(r2 - {1'b0, dm}) : r2[67:0];
			quo_q  <= {quo_q[33:0], r2_ge};
			nlow_q <= {nlow_q[33:0], 1'b0};
		end
	end

	// crossing operands and result
	always_ff @(posedge clk) begin
		if (cmd.ld_den)
			den_q <= acc_q[67:0];
		if (cmd.ld_num)
			num_q <= acc_q[67:0];
		if (cmd.r_from_a)
			r_q <= ea;
		else if (cmd.fin) begin
			case (comp_q)
				2'd0:    r_q[0] <= comp_res;
				2'd1:    r_q[1] <= comp_res;
				2'd2:    r_q[2] <= comp_res;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			comp_q <= 2'd0;
		else if (cmd.comp_clr)
			comp_q <= 2'd0;
		else if (cmd.comp_inc)
			comp_q <= comp_q + 2'd1;
	end

	// vertex and polygon payload
	always_ff @(posedge clk) begin
		if (cmd.ld_v) begin
			v_q    <= {in_data.vertex_z, in_data.vertex_y, in_data.vertex_x};
			last_q <= in_data.last_vertex;
		end
		if (cmd.ld_side)
			s_q <= side_cur;
		if (cmd.dec_first) begin
			first_q      <= v_q;
			prev_q       <= v_q;
			first_side_q <= side_cur;
			prev_side_q  <= side_cur;
		end else if (cmd.advance) begin
			prev_q      <= v_q;
			prev_side_q <= s_q;
		end
		if (cmd.set_pending)
			pend_q <= r_q;
	end

	// nearest point tracking
	logic [63:0] dsat;
	logic        far;
	assign dsat = (|acc_q[65:64]) ? '1 : acc_q[63:0];
	assign far  = acc_q[65:0] >= {3'd0, tol_q};

	always_ff @(posedge clk) begin
		if (cmd.best_upd && (!bv_q || dsat < best_dist_q))
			best_q <= pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 2'd0;
			pv_q        <= 1'b0;
			bv_q        <= 1'b0;
			best_dist_q <= '1;
		end else begin
			if (cmd.clear_poly) begin
				seen_q      <= 2'd0;
				pv_q        <= 1'b0;
				bv_q        <= 1'b0;
				best_dist_q <= '1;
			end else begin
				if (cmd.dec_first)
					seen_q <= 2'd1;
				else if (cmd.advance && seen_q != 2'd2)
					seen_q <= seen_q + 2'd1;
				if (cmd.set_pending)
					pv_q <= 1'b1;
				if (cmd.best_upd && (!bv_q || dsat < best_dist_q)) begin
					bv_q        <= 1'b1;
					best_dist_q <= dsat;
				end
			end
		end
	end

	// result register
	result_t res;
	always_comb begin
		res                 = '0;
		res.last_of_polygon = cmd.emit_last;
		case (cmd.emit_kind)
			EMIT_PENDING: begin
				res.point_x = pend_q[0];
				res.point_y = pend_q[1];
				res.point_z = pend_q[2];
				res.status  = ST_OK;
			end
			EMIT_BEST: begin
				if (bv_q) begin
					res.point_x = best_q[0];
					res.point_y = best_q[1];
					res.point_z = best_q[2];
					res.status  = ST_OK;
				end else begin
					res.status = ST_NONE;
				end
			end
			EMIT_NONE:  res.status = ST_NONE;
			EMIT_SHORT: res.status = ST_SHORT;
			default:    res.status = ST_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		stat              = '0;
		stat.mac_done     = cmd.mac_go && (mac_cnt_q == 2'd3);
		stat.div_done     = cmd.div_go && (div_cnt_q == 6'(DIV_STEPS - 1));
		stat.side_change  = side_cur != prev_side_q;
		stat.close_needed = (first_side_q != s_q) && (first_side_q != SIDE_ON);
		stat.den_small    = dm <= SIDE_TOL;
		stat.far          = far;
		stat.pend_valid   = pv_q;
		stat.closest      = closest_q;
		stat.out_free     = !out_valid_q || out_ready;
		stat.comp_last    = comp_q == 2'd2;
		stat.last_v       = last_q;
		stat.seen_zero    = seen_q == 2'd0;
	end

endmodule

/* sv/ppi_ctrl.sv */
// Controller: sequences classification, crossing, merge and release steps
// through the datapath. Depends on ppi_pkg.
`timescale 1ns / 1ps
module ppi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppi_pkg::dp_stat_t  stat,
	output ppi_pkg::dp_cmd_t   cmd
);
	import ppi_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE    = 22'h000001,
		S_SIDE    = 22'h000002,
		S_DECIDE  = 22'h000004,
		S_SHORT   = 22'h000008,
		S_CDEN    = 22'h000010,
		S_CDEN_LD = 22'h000020,
		S_CNUM    = 22'h000040,
		S_CCHK    = 22'h000080,
		S_CMUL    = 22'h000100,
		S_CDIV0   = 22'h000200,
		S_CDIV    = 22'h000400,
		S_CFIN    = 22'h000800,
		S_PUSH    = 22'h001000,
		S_MDIST   = 22'h002000,
		S_MCMP    = 22'h004000,
		S_RCONS   = 22'h008000,
		S_RBEST   = 22'h010000,
		S_REMIT   = 22'h020000,
		S_PSET    = 22'h040000,
		S_ADVANCE = 22'h080000,
		S_FREL    = 22'h100000,
		S_FEND    = 22'h200000
	} state_t;

	state_t state_q, state_d;
	logic   closing_q, closing_d;
	logic   final_q, final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			closing_q <= 1'b0;
			final_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			closing_q <= closing_d;
			final_q   <= final_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		closing_d      = closing_q;
		final_d        = final_q;
		cmd            = '0;
		cmd.edge_close = closing_q;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_v = 1'b1;
					state_d  = S_SIDE;
				end
			end
			S_SIDE: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_DOT_VP;
				if (stat.mac_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.ld_side = 1'b1;
				if (stat.seen_zero) begin
					cmd.dec_first = 1'b1;
					state_d       = stat.last_v ? S_SHORT : S_IDLE;
				end else if (stat.side_change) begin
					closing_d = 1'b0;
					state_d   = S_CDEN;
				end else begin
					state_d = S_ADVANCE;
				end
			end
			S_SHORT: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_kind  = EMIT_SHORT;
					cmd.emit_last  = 1'b1;
					cmd.clear_poly = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_CDEN: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_DOT_BA;
				if (stat.mac_done)
					state_d = S_CDEN_LD;
			end
			S_CDEN_LD: begin
				cmd.ld_den = 1'b1;
				state_d    = S_CNUM;
			end
			S_CNUM: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_DOT_PA;
				if (stat.mac_done)
					state_d = S_CCHK;
			end
			S_CCHK: begin
				cmd.ld_num = 1'b1;
				// edge parallel to the plane: take its start point
				if (stat.den_small) begin
					cmd.r_from_a = 1'b1;
					state_d      = S_PUSH;
				end else begin
					cmd.comp_clr = 1'b1;
					state_d      = S_CMUL;
				end
			end
			S_CMUL: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_CHUNK;
				if (stat.mac_done)
					state_d = S_CDIV0;
			end
			S_CDIV0: begin
				cmd.div_init = 1'b1;
				state_d      = S_CDIV;
			end
			S_CDIV: begin
				cmd.div_go = 1'b1;
				if (stat.div_done)
					state_d = S_CFIN;
			end
			S_CFIN: begin
				cmd.fin      = 1'b1;
				cmd.comp_inc = 1'b1;
				state_d      = stat.comp_last ? S_PUSH : S_CMUL;
			end
			S_PUSH: begin
				state_d = stat.pend_valid ? S_MDIST : S_PSET;
			end
			S_MDIST: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_SQ_RP;
				if (stat.mac_done)
					state_d = S_MCMP;
			end
			S_MCMP: begin
				// too close to the waiting point: drop it, keep the new one
				if (stat.far) begin
					final_d = 1'b0;
					state_d = S_RCONS;
				end else begin
					state_d = S_PSET;
				end
			end
			S_RCONS: begin
				cmd.mac_go   = 1'b1;
				cmd.mac_mode = MAC_SQ_QP;
				if (stat.mac_done)
					state_d = S_RBEST;
			end
			S_RBEST: begin
				cmd.best_upd = 1'b1;
				if (!stat.closest)
					state_d = S_REMIT;
				else
					state_d = final_q ? S_FEND : S_PSET;
			end
			S_REMIT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = EMIT_PENDING;
					cmd.emit_last = final_q;
					state_d       = final_q ? S_FEND : S_PSET;
				end
			end
			S_PSET: begin
				cmd.set_pending = 1'b1;
				state_d         = closing_q ? S_FREL : S_ADVANCE;
			end
			S_ADVANCE: begin
				cmd.advance = 1'b1;
				if (!stat.last_v)
					state_d = S_IDLE;
				else if (stat.close_needed) begin
					closing_d = 1'b1;
					state_d   = S_CDEN;
				end else
					state_d = S_FREL;
			end
			S_FREL: begin
				if (stat.pend_valid) begin
					final_d = 1'b1;
					state_d = S_RCONS;
				end else begin
					state_d = S_FEND;
				end
			end
			S_FEND: begin
				if (stat.closest || !stat.pend_valid) begin
					if (stat.out_free) begin
						cmd.emit       = 1'b1;
						cmd.emit_kind  = stat.closest ? EMIT_BEST : EMIT_NONE;
						cmd.emit_last  = 1'b1;
						cmd.clear_poly = 1'b1;
						closing_d      = 1'b0;
						final_d        = 1'b0;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.clear_poly = 1'b1;
					closing_d      = 1'b0;
					final_d        = 1'b0;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* sv/polygon_plane_intersection.sv */
// Polygon/plane intersection top level: controller, datapath and checks.
// Depends on ppi_pkg, ppi_ctrl, ppi_datapath and assert_macros.svh.
//
//   channel   dir  handshake             payload
//   in        in   in_valid / in_ready   in_data  (vertex_t, one vertex a beat)
//   out       out  out_valid / out_ready out_data (result_t, one result a beat)
//   cfg       in   cfg_wr_en             cfg_index, cfg_data
//
// One vertex at a time. Each edge crossing not parallel to the plane runs the
// shared divider, which yields one quotient bit a cycle, 35 bits for each of three components.
// Reset clears the controller, polygon state and registers to their defaults.
// A stalled output holds the controller only when a further result is due;
// the next vertex is taken while the last result of a polygon waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polygon_plane_intersection (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ppi_pkg::vertex_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ppi_pkg::result_t               out_data,
	input  logic                           cfg_wr_en,
	input  logic [ppi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppi_pkg::CFG_W-1:0]      cfg_data
);
	import ppi_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ppi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	`PPI_NEVER(a_emit_over_beat, cmd.emit && !stat.out_free, "result written over an untaken beat")
	`PPI_NEVER(a_zero_point, out_valid && out_data.status != ST_OK && (out_data.point_x != 0 || out_data.point_y != 0 || out_data.point_z != 0), "non-zero point on a failed result")
	`PPI_NEVER(a_short_last, out_valid && out_data.status == ST_SHORT && !out_data.last_of_polygon, "short polygon result not marked last")
	`PPI_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "vertex taken while busy")

endmodule

/* tb/sv/ppi_checker.sv */
// Scoreboard for the polygon/plane intersection block: watches vertex, result and register ports.
// Keeps its own copy of the polygon state and the registers; needs ppi_pkg only.
`timescale 1ns / 1ps
module ppi_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  ppi_pkg::vertex_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  ppi_pkg::result_t              out_data,
	input  logic                          cfg_wr_en,
	input  logic [ppi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppi_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            results_due,
	output int                            results_seen
);
	import ppi_pkg::*;

	typedef logic [2:0][63:0] coord3_t;

	// register copy
	logic [2:0][31:0] nrm;
	coord3_t          plane_pt;
	logic [62:0]      merge_tol;
	logic             closest;

	// polygon state
	coord3_t     first_v, prev_v, pend_v, best_v;
	logic [1:0]  first_side, prev_side;
	int          seen;
	logic        pend_ok, best_ok;
	logic [63:0] best_dist;

	result_t point_q[$];

	function automatic logic signed [127:0] normal_dot(coord3_t a, coord3_t b);
		logic signed [127:0] s, n1, d1;
		s = 0;
		for (int c = 0; c < 3; c++) begin
			n1 = $signed(nrm[c]);
			d1 = $signed(a[c]) - $signed(b[c]);
			s = s + n1 * d1;
		end
		return s;
	endfunction

	function automatic logic [127:0] sq_dist(coord3_t a, coord3_t b);
		logic [127:0] s;
		logic signed [63:0] d;
		logic [127:0] m;
		s = 0;
		for (int c = 0; c < 3; c++) begin
			d = $signed(a[c]) - $signed(b[c]);
			m = (d < 0) ? -d : d;
			s = s + m * m;
		end
		return s;
	endfunction

	function automatic logic [1:0] side_of(coord3_t v);
		logic signed [127:0] d;
		d = normal_dot(v, plane_pt);
		if (d == 0)
			return SIDE_ON;
		return (d < 0) ? SIDE_BELOW : SIDE_ABOVE;
	endfunction

	// crossing of edge a->b with the plane, offsets rounded half away from zero
	function automatic coord3_t edge_crossing(coord3_t a, coord3_t b);
		logic signed [127:0] den, num;
		logic [127:0] dm, nm, prod, q, rem, cap;
		logic signed [63:0] diff, v;
		logic [63:0] dabs;
		logic neg;
		coord3_t r;
		den = normal_dot(b, a);
		num = normal_dot(plane_pt, a);
		dm = (den < 0) ? -den : den;
		if (dm == 0)
			return a;
		nm = (num < 0) ? -num : num;
		for (int c = 0; c < 3; c++) begin
			diff = $signed(b[c]) - $signed(a[c]);
			dabs = (diff < 0) ? -diff : diff;
			prod = nm * {64'd0, dabs};
			q = prod / dm;
			rem = prod % dm;
			if ((rem << 1) >= dm)
				q = q + 1;
			neg = (num < 0) ^ (den < 0) ^ (diff < 0);
			cap = (q > (128'd1 << 34)) ? (128'd1 << 34) : q;
			v = neg ? $signed(a[c]) - $signed(cap[63:0]) : $signed(a[c]) + $signed(cap[63:0]);
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
			r[c] = v;
		end
		return r;
	endfunction

	task automatic queue_point(coord3_t p, logic [1:0] st, logic last);
		result_t r;
		r.point_x = p[0][31:0];
		r.point_y = p[1][31:0];
		r.point_z = p[2][31:0];
		r.status = st;
		r.last_of_polygon = last;
		point_q = {point_q, r};
	endtask

	task automatic release_pending(logic last);
		logic [127:0] d;
		logic [63:0] ds;
		d = sq_dist(pend_v, plane_pt);
		ds = (d[127:64] != 0) ? '1 : d[63:0];
		if (!best_ok || ds < best_dist) begin
			best_dist = ds;
			best_v = pend_v;
			best_ok = 1'b1;
		end
		if (!closest)
			queue_point(pend_v, ST_OK, last);
	endtask

	task automatic push_crossing(coord3_t q);
		if (pend_ok && sq_dist(q, pend_v) >= {65'd0, merge_tol})
			release_pending(1'b0);
		pend_v = q;
		pend_ok = 1'b1;
	endtask

	task automatic clear_polygon();
		seen = 0;
		pend_ok = 1'b0;
		best_ok = 1'b0;
		best_dist = '1;
	endtask

	task automatic predict_vertex(vertex_t vx);
		coord3_t v;
		logic [1:0] s;
		v[0] = 64'($signed(vx.vertex_x));
		v[1] = 64'($signed(vx.vertex_y));
		v[2] = 64'($signed(vx.vertex_z));
		s = side_of(v);
		if (seen == 0) begin
			first_v = v;
			prev_v = v;
			first_side = s;
			prev_side = s;
			seen = 1;
			if (vx.last_vertex) begin
				queue_point('0, ST_SHORT, 1'b1);
				clear_polygon();
			end
			return;
		end
		if (s != prev_side)
			push_crossing(edge_crossing(prev_v, v));
		prev_v = v;
		prev_side = s;
		if (seen < 2)
			seen++;
		if (vx.last_vertex) begin
			// closing edge only when the first vertex is off the plane
			if (first_side != s && first_side != SIDE_ON)
				push_crossing(edge_crossing(v, first_v));
			if (pend_ok)
				release_pending(1'b1);
			if (closest) begin
				if (best_ok)
					queue_point(best_v, ST_OK, 1'b1);
				else
					queue_point('0, ST_NONE, 1'b1);
			end else if (!pend_ok) begin
				queue_point('0, ST_NONE, 1'b1);
			end
			clear_polygon();
		end
	endtask

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t ppi_checker: result %0d %s got %h want %h", $time, results_seen,
			field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			nrm = '0;
			nrm[2] = 32'd65536;
			plane_pt = '0;
			merge_tol = 63'd1;
			closest = 1'b0;
			first_v = '0;
			prev_v = '0;
			pend_v = '0;
			best_v = '0;
			first_side = SIDE_ON;
			prev_side = SIDE_ON;
			clear_polygon();
			point_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_NORMAL_X: nrm[0] = cfg_data[31:0];
					REG_NORMAL_Y: nrm[1] = cfg_data[31:0];
					REG_NORMAL_Z: nrm[2] = cfg_data[31:0];
					REG_PLANE_X: plane_pt[0] = 64'($signed(cfg_data[31:0]));
					REG_PLANE_Y: plane_pt[1] = 64'($signed(cfg_data[31:0]));
					REG_PLANE_Z: plane_pt[2] = 64'($signed(cfg_data[31:0]));
					REG_MERGE_TOL: merge_tol = cfg_data;
					REG_CLOSEST: closest = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_vertex(in_data);
			if (out_valid && out_ready) begin
				if (point_q.size() == 0) begin
					report("unexpected beat", out_data.point_x, 32'd0);
				end else begin
					want = point_q.pop_front();
					if (out_data.point_x !== want.point_x)
						report("point_x", out_data.point_x, want.point_x);
					if (out_data.point_y !== want.point_y)
						report("point_y", out_data.point_y, want.point_y);
					if (out_data.point_z !== want.point_z)
						report("point_z", out_data.point_z, want.point_z);
					if (out_data.status !== want.status)
						report("status", 32'(out_data.status), 32'(want.status));
					if (out_data.last_of_polygon !== want.last_of_polygon)
						report("last_of_polygon", 32'(out_data.last_of_polygon),
							32'(want.last_of_polygon));
				end
				results_seen++;
			end
		end
		results_due = point_q.size();
	end

endmodule

/* tb/sv/polygon_plane_intersection_tb.sv */
// Testbench top for polygon_plane_intersection: clock, reset, vertex and register stimulus.
// Depends on ppi_pkg, the block and ppi_checker, which does all result checking.
`timescale 1ns / 1ps
module polygon_plane_intersection_tb;
	import ppi_pkg::*;

	localparam int SETTLE = 1500;
	localparam int STALL_LIMIT = 40000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	vertex_t in_data;
	result_t out_data;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int errors, results_due, results_seen;
	int vertices_sent;
	int quiet_cycles = 0;
	int hold_requests;

	polygon_plane_intersection u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ppi_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .results_due(results_due), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("polygon_plane_intersection_tb: FAIL");
			$finish;
		end
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		int k;
		int holds_done;
		holds_done = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holds_done < hold_requests) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				holds_done++;
			end
			k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (k > 0) begin
				out_ready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// hold the write for one edge, then deassert the write enable before returning
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_s32(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		write_reg(idx, {31'd0, val});
	endtask

	// drain every due result, then let a vertex with no result finish its work
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
		int gap;
		gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= '{vertex_x: x, vertex_y: y, vertex_z: z, last_vertex: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		vertices_sent++;
	endtask

	function automatic logic [31:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
		if (sel < 8)
			return 32'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16);
		return $urandom();
	endfunction

	task automatic send_polygon(int n);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	task automatic random_polygons(int count);
		int left, n;
		left = count;
		while (left > 0) begin
			n = $urandom_range(1, 6);
			if (n > left)
				n = left;
			send_polygon(n);
			left -= n;
		end
	endtask

	task automatic random_geometry();
		for (int r = 0; r < 6; r++)
			write_s32(CFG_IDX_W'(REG_NORMAL_X + r),
				($urandom_range(0, 1) != 0) ? $urandom() : rand_coord());
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_requests = 0;
		vertices_sent = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, plane z = 0
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		send_vertex(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h0, 32'h0001_0000, 32'hffff_0000, 1'b0);
		send_vertex(32'hffff_0000, 32'h0, 32'h0002_0000, 1'b1);
		send_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h0001_0000, 32'h0, 32'h0003_0000, 1'b1);
		send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
		send_vertex(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h0, 32'h0001_0000, 32'hffff_0000, 1'b1);
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_vertex(32'h0, 32'h0, 32'h0000_0001, 1'b0);
		send_vertex(32'h0, 32'h0, 32'hffff_ffff, 1'b1);
		drain();

		// merge near points, keep only the nearest
		write_reg(REG_MERGE_TOL, 63'h0000_0100_0000_0000);
		write_reg(REG_CLOSEST, 63'd1);
		send_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h0, 32'h0, 32'hffff_0000, 1'b0);
		send_vertex(32'h0000_0100, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h7fff_0000, 32'h7fff_0000, 32'hffff_0000, 1'b1);
		random_polygons(30);
		send_vertex(32'h0005_0000, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'h0005_0000, 32'h0, 32'hffff_0000, 1'b0);
		drain();

		// switch mode halfway through an open polygon
		write_reg(REG_CLOSEST, 63'd0);
		send_vertex(32'hfffb_0000, 32'h0, 32'h0001_0000, 1'b0);
		send_vertex(32'hfffb_0000, 32'h0, 32'hffff_0000, 1'b1);
		drain();

		// extreme geometry, largest merge tolerance
		write_s32(REG_NORMAL_X, 32'h8000_0000);
		write_s32(REG_NORMAL_Y, 32'h7fff_ffff);
		write_s32(REG_NORMAL_Z, 32'h0000_0001);
		write_s32(REG_PLANE_X, 32'h7fff_ffff);
		write_s32(REG_PLANE_Y, 32'h8000_0000);
		write_s32(REG_PLANE_Z, $urandom());
		write_reg(REG_MERGE_TOL, 63'h7fff_ffff_ffff_ffff);
		random_polygons(30);
		drain();

		// no merging, random plane; hold the result side off while vertices pile up
		write_reg(REG_MERGE_TOL, 63'd0);
		random_geometry();
		hold_requests++;
		random_polygons(60);
		drain();

		// degenerate normal puts every vertex on the plane
		write_s32(REG_NORMAL_X, 32'h0);
		write_s32(REG_NORMAL_Y, 32'h0);
		write_s32(REG_NORMAL_Z, 32'h0);
		write_reg(REG_MERGE_TOL, 63'd1);
		random_polygons(15);
		drain();

		random_geometry();
		write_reg(REG_MERGE_TOL, {31'd0, $urandom()});
		write_reg(REG_CLOSEST, 63'($urandom_range(0, 1)));
		random_polygons(40);
		drain();

		$display("Covered %0d vertices and %0d results over defaults, merge, nearest-only,",
			vertices_sent, results_seen);
		$display("extreme and degenerate planes, a mid-polygon mode switch and a long stall.");
		if (errors == 0)
			$display("polygon_plane_intersection_tb: PASS");
		else
			$display("polygon_plane_intersection_tb: FAIL");
		$finish;
	end

endmodule

/* polygon_plane_intersection.f */
+incdir+sv
sv/ppi_pkg.sv
sv/ppi_datapath.sv
sv/ppi_ctrl.sv
sv/polygon_plane_intersection.sv
tb/sv/ppi_checker.sv
tb/sv/polygon_plane_intersection_tb.sv
